### sv/pgmap_pkg.sv
// ----------------------------------------------------------------------------
// Page map lookup package
// Shared types, codes and constants of the memory page map lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package pgmap_pkg;

  localparam int RAM_PAGE_BYTES = 1024;
  localparam int PAGE_SHIFT     = $clog2(RAM_PAGE_BYTES);

  localparam logic [31:0] SMALL_AREA_BYTES   = 32'h0001_0000;
  localparam logic [15:0] SMALL_SECTOR_COUNT = 16'd16;
  localparam int          SMALL_SECTOR_SHIFT = 12;
  localparam int          LARGE_SECTOR_SHIFT = 15;
  localparam logic [15:0] SMALL_SECTOR_BYTES = 16'd4096;
  localparam logic [15:0] LARGE_SECTOR_BYTES = 16'd32768;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BYTES = 3'd4;

  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_RAM   = 2'd1;
  localparam logic [1:0] REQ_FLASH = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_BADREQ = 2'd2;

  localparam logic KIND_RAM   = 1'b0;
  localparam logic KIND_FLASH = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [15:0] page_number;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        page_kind;
    logic [15:0] found_page;
    logic [31:0] page_base;
    logic [15:0] page_bytes;
  } out_t;

  typedef struct packed {
    logic [31:0] main_ram_base;
    logic [24:0] main_ram_bytes;
    logic [31:0] aux_ram_base;
    logic [24:0] aux_ram_bytes;
    logic [24:0] flash_bytes;
  } cfg_t;

endpackage

`default_nettype wire

### sv/pgmap_cfg.sv
// ----------------------------------------------------------------------------
// Page map configuration registers
// Holds the region bases and sizes, written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmap_cfg
  import pgmap_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAIN_BASE:   cfg_nxt.main_ram_base  = cfg_data;
        CFG_MAIN_BYTES:  cfg_nxt.main_ram_bytes = cfg_data[24:0];
        CFG_AUX_BASE:    cfg_nxt.aux_ram_base   = cfg_data;
        CFG_AUX_BYTES:   cfg_nxt.aux_ram_bytes  = cfg_data[24:0];
        CFG_FLASH_BYTES: cfg_nxt.flash_bytes    = cfg_data[24:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.main_ram_base  <= 32'h1000_0000;
      cfg_r.main_ram_bytes <= 25'd32768;
      cfg_r.aux_ram_base   <= 32'h2007_C000;
      cfg_r.aux_ram_bytes  <= 25'd32768;
      cfg_r.flash_bytes    <= 25'd524288;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/pgmap_decode.sv
// ----------------------------------------------------------------------------
// Page map decoder
// Combinational address and page number decode for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmap_decode
  import pgmap_pkg::*;
(
  input  wire cfg_t cfg,
  input  wire in_t  req,
  output out_t      res
);

  logic [32:0] addr_end;
  logic [32:0] main_end;
  logic [32:0] aux_end;
  logic        fit_main;
  logic        fit_aux;
  logic        in_aux;
  logic [31:0] origin;
  logic [15:0] first;
  logic [31:0] diff;
  logic [31:0] idx;
  logic [31:0] page_mask;
  logic [24:0] main_pages;
  logic [24:0] aux_pages;
  logic [25:0] all_pages;
  logic [25:0] pnum_ext;
  logic        flash_hit;
  logic        small_hit;
  logic [15:0] fq_page;
  logic [31:0] fq_base;
  logic [15:0] pnum_minus;
  logic [33:0] fp_base;
  logic [33:0] fp_end;
  logic [15:0] fp_bytes;
  logic [31:0] rp_off;
  logic [31:0] rp_aux_off;

  assign page_mask  = ~((32'd1 << PAGE_SHIFT) - 32'd1);
  assign main_pages = cfg.main_ram_bytes >> PAGE_SHIFT;
  assign aux_pages  = cfg.aux_ram_bytes >> PAGE_SHIFT;
  assign all_pages  = {1'b0, main_pages} + {1'b0, aux_pages};
  assign pnum_ext   = {10'd0, req.page_number};

  assign addr_end = {1'b0, req.address} + 33'(RAM_PAGE_BYTES);
  assign main_end = {1'b0, cfg.main_ram_base} + {8'd0, cfg.main_ram_bytes};
  assign aux_end  = {1'b0, cfg.aux_ram_base} + {8'd0, cfg.aux_ram_bytes};
  assign fit_main = (req.address >= cfg.main_ram_base) && (addr_end <= main_end);
  assign fit_aux  = (req.address >= cfg.aux_ram_base) && (addr_end <= aux_end);
  assign in_aux   = (req.address >= cfg.aux_ram_base) && ({1'b0, req.address} < aux_end);
  assign origin   = in_aux ? cfg.aux_ram_base : cfg.main_ram_base;
  assign first    = in_aux ? main_pages[15:0] : 16'd0;
  assign diff     = req.address - origin;
  assign idx      = diff >> PAGE_SHIFT;

  assign flash_hit = req.address < {7'd0, cfg.flash_bytes};
  assign small_hit = req.address < SMALL_AREA_BYTES;
  assign fq_page   = small_hit ? 16'(req.address >> SMALL_SECTOR_SHIFT)
                   : 16'(SMALL_SECTOR_COUNT
                         + 16'((req.address - SMALL_AREA_BYTES) >> LARGE_SECTOR_SHIFT));
  assign fq_base   = small_hit ? {req.address[31:SMALL_SECTOR_SHIFT], 12'd0}
                   : {req.address[31:LARGE_SECTOR_SHIFT], 15'd0};

  assign pnum_minus = req.page_number - SMALL_SECTOR_COUNT;
  assign fp_bytes   = (req.page_number < SMALL_SECTOR_COUNT) ? SMALL_SECTOR_BYTES
                    : LARGE_SECTOR_BYTES;
  assign fp_base    = (req.page_number < SMALL_SECTOR_COUNT)
                    ? {6'd0, req.page_number, 12'd0}
                    : {3'd0, pnum_minus, 15'd0} + {2'd0, SMALL_AREA_BYTES};
  assign fp_end     = fp_base + {18'd0, fp_bytes};

  assign rp_off     = 32'(req.page_number) << PAGE_SHIFT;
  assign rp_aux_off = 32'(req.page_number - main_pages[15:0]) << PAGE_SHIFT;

  always_comb begin
    res = '0;
    case (req.req_type)
      REQ_QUERY: begin
        if (fit_main || fit_aux) begin
          res.status     = ST_OK;
          res.page_kind  = KIND_RAM;
          res.found_page = 16'(first + idx[15:0]);
          res.page_base  = origin + (diff & page_mask);
          res.page_bytes = 16'(RAM_PAGE_BYTES);
        end else if (flash_hit) begin
          res.status     = ST_OK;
          res.page_kind  = KIND_FLASH;
          res.found_page = fq_page;
          res.page_base  = fq_base;
          res.page_bytes = small_hit ? SMALL_SECTOR_BYTES : LARGE_SECTOR_BYTES;
        end else begin
          res.status = ST_ABSENT;
        end
      end
      REQ_RAM: begin
        if (pnum_ext < {1'b0, main_pages}) begin
          res.status     = ST_OK;
          res.page_kind  = KIND_RAM;
          res.found_page = req.page_number;
          res.page_base  = cfg.main_ram_base + rp_off;
          res.page_bytes = 16'(RAM_PAGE_BYTES);
        end else if (pnum_ext < all_pages) begin
          res.status     = ST_OK;
          res.page_kind  = KIND_RAM;
          res.found_page = req.page_number;
          res.page_base  = cfg.aux_ram_base + rp_aux_off;
          res.page_bytes = 16'(RAM_PAGE_BYTES);
        end else begin
          res.status = ST_ABSENT;
        end
      end
      REQ_FLASH: begin
        if (fp_end > {9'd0, cfg.flash_bytes}) begin
          res.status = ST_ABSENT;
        end else begin
          res.status     = ST_OK;
          res.page_kind  = KIND_FLASH;
          res.found_page = req.page_number;
          res.page_base  = fp_base[31:0];
          res.page_bytes = fp_bytes;
        end
      end
      default: begin
        res.status = ST_BADREQ;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/memory_page_map_lookup.sv
// ----------------------------------------------------------------------------
// Memory page map lookup
// Maps addresses to RAM and flash pages and page numbers to page extents.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  in_data   (in_t)
//   out      output     out_valid / out_stall out_data (out_t)
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request passes from input transfer to result through an input register
// and a result register; one request is taken every cycle unless in_stall is high.
// The decode between the two registers sets the clock period.
// Reset is synchronous, clears both stage valids and loads register defaults.
// A stalled result holds both stages; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_page_map_lookup
  import pgmap_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cfg_t cfg;
  out_t dec_res;

  logic s1_valid_r;
  logic s1_valid_nxt;
  in_t  s1_data_r;
  logic out_valid_r;
  logic out_valid_nxt;
  out_t out_data_r;
  logic out_adv;
  logic s1_load;

  pgmap_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgmap_decode u_decode (
    .cfg (cfg),
    .req (s1_data_r),
    .res (dec_res)
  );

  assign out_adv   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_adv;
  assign s1_load   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (!s1_valid_r || out_adv) begin
      s1_valid_nxt = in_valid;
    end
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (s1_valid_r && out_adv) begin
      out_data_r <= dec_res;
    end
  end

`ifndef SYNTHESIS
  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_OK |->
      out_data_r.page_kind == 1'b0 && out_data_r.found_page == 16'd0 &&
      out_data_r.page_base == 32'd0 && out_data_r.page_bytes == 16'd0)
    else $error("failed result carries nonzero page fields");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status == ST_OK || out_data_r.status == ST_ABSENT ||
                    out_data_r.status == ST_BADREQ)
    else $error("result status out of range");

  a_flash_size : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_OK && out_data_r.page_kind == KIND_FLASH |->
      out_data_r.page_bytes == SMALL_SECTOR_BYTES ||
      out_data_r.page_bytes == LARGE_SECTOR_BYTES)
    else $error("flash page with unexpected sector size");

  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_adv |=> out_valid_r)
    else $error("request lost between input and result register");
`endif

endmodule

`default_nettype wire
